[hdl/sclru_pkg.sv]
// Shared types and constants of the sector cache tag and replacement engine.
package sclru_pkg;

  // Field widths of the request and result items.
  localparam int LBA_W       = 32;
  localparam int LINE_FW     = 4;
  localparam int OFFS_FW     = 3;
  localparam int CNT_FW      = 4;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  // Request kinds carried on s_tuser.
  localparam logic [1:0] KIND_LOOKUP     = 2'd0;
  localparam logic [1:0] KIND_FILL_DONE  = 2'd1;
  localparam logic [1:0] KIND_INVALIDATE = 2'd2;

  // Saturation value of a line age; empty lines read as this age.
  localparam logic [7:0] AGE_MAX = 8'd255;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_SCAN_DONE,
    ST_FILL,
    ST_AGE,
    ST_AGE_DRAIN,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the accepted request
    logic idx_clr;     // restart the line walk at line 0
    logic issue_scan;  // read the current line for the tag scan
    logic issue_age;   // read the current line for the aging pass
    logic fill_write;  // write the pending fill into its line
    logic commit;      // load the result and update pending and valid state
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       fill_ok;
    logic       pend_valid;
    logic       found;
    logic       idx_last;
    logic       out_free;
  } dp_status_t;

endpackage

[hdl/sclru_ctrl.sv]
// Controller state machine that sequences scan, fill and aging passes.
module sclru_ctrl
  import sclru_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status.kind)
          KIND_LOOKUP: state_next = ST_SCAN;
          KIND_FILL_DONE: begin
            if (status.pend_valid && status.fill_ok) begin
              state_next = ST_FILL;
            end else begin
              state_next = ST_DONE;
            end
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        if (status.idx_last) begin
          state_next = ST_SCAN_DRAIN;
        end
      end
      ST_SCAN_DRAIN: state_next = ST_SCAN_DONE;
      ST_SCAN_DONE: begin
        if (status.found) begin
          state_next = ST_AGE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_FILL: state_next = ST_AGE;
      ST_AGE: begin
        if (status.idx_last) begin
          state_next = ST_AGE_DRAIN;
        end
      end
      ST_AGE_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_DISPATCH: cmd.idx_clr = 1'b1;
      ST_SCAN: cmd.issue_scan = 1'b1;
      ST_SCAN_DONE: cmd.idx_clr = 1'b1;
      ST_FILL: begin
        cmd.fill_write = 1'b1;
        cmd.idx_clr    = 1'b1;
      end
      ST_AGE: cmd.issue_age = 1'b1;
      ST_DONE: cmd.commit = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[hdl/sclru_dp.sv]
// Datapath: line memories, scan and victim trackers, aging, pending fill and result register.
module sclru_dp
  import sclru_pkg::*;
#(
  parameter int LINE_COUNT = 16,
  parameter int READ_AHEAD = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [LBA_W-1:0]       cfg_wdata,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [1:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  dp_cmd_t                cmd,
  output dp_status_t             status
);

  localparam int LW = $clog2(LINE_COUNT);
  localparam int CW = $clog2(READ_AHEAD + 1);
  localparam logic [LW-1:0]    IDX_LAST = LW'(LINE_COUNT - 1);
  localparam logic [CW-1:0]    RA_FULL  = CW'(READ_AHEAD);
  localparam logic [CW-1:0]    RA_ONE   = CW'(1);
  localparam logic [LBA_W-1:0] RA_WIDE  = LBA_W'(READ_AHEAD);

  // Configuration and captured request.
  logic [LBA_W-1:0] disk_total;
  logic [1:0]       kind;
  logic [LBA_W-1:0] lba;
  logic             fill_ok;

  // Line storage: start and count written together on a fill, ages apart.
  logic [LBA_W-1:0]      start_mem [LINE_COUNT];
  logic [CW-1:0]         cnt_mem   [LINE_COUNT];
  logic [7:0]            age_mem   [LINE_COUNT];
  logic [LINE_COUNT-1:0] valid;

  // Walk counter and read pipeline.
  logic [LW-1:0]    idx;
  logic [LW-1:0]    e_idx;
  logic             e_scan;
  logic             e_age;
  logic [LBA_W-1:0] start_q;
  logic [CW-1:0]    cnt_q;
  logic [7:0]       age_q;
  logic             v_q;

  // Scan trackers.
  logic                found;
  logic [LW-1:0]       hit_idx;
  logic [OFFS_FW-1:0]  hit_offs;
  logic                empty_found;
  logic [LW-1:0]       empty_idx;
  logic [7:0]          oldest_age;
  logic [LW-1:0]       best_idx;

  // Pending fill.
  logic             pend_valid;
  logic [LW-1:0]    pend_line;
  logic [LBA_W-1:0] pend_start;
  logic [CW-1:0]    pend_count;

  // Result register.
  logic                out_vld;
  logic                out_hit;
  logic [LINE_FW-1:0]  out_hit_line;
  logic [OFFS_FW-1:0]  out_offs;
  logic                out_fill_req;
  logic [LINE_FW-1:0]  out_fill_line;
  logic [LBA_W-1:0]    out_fill_lba;
  logic [CNT_FW-1:0]   out_fill_count;

  // Combinational terms.
  logic [LBA_W:0]           scan_diff;
  logic [LBA_W-1:0]         cnt_wide;
  logic                     hit_here;
  logic [7:0]               age_eff;
  logic [LW-1:0]            young;
  logic [7:0]               age_new;
  logic                     age_we;
  logic [LBA_W:0]           tot_diff;
  logic [CW-1:0]            ra;
  logic [LW-1:0]            victim;
  logic [LW+LINE_FW-1:0]    hit_line_ext;
  logic [LW+LINE_FW-1:0]    victim_ext;
  logic [CW+CNT_FW-1:0]     ra_ext;
  logic                     out_free;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_total <= '0;
    end else if (cfg_wen) begin
      disk_total <= cfg_wdata;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind    <= s_tuser;
      lba     <= s_tdata[LBA_W-1:0];
      fill_ok <= s_tdata[LBA_W];
    end
  end

  // Line walk counter.
  always_ff @(posedge clk) begin
    if (rst || cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.issue_scan || cmd.issue_age) begin
      idx <= idx + 1'b1;
    end
  end

  // Registered reads of the current line and the evaluation stage tags.
  always_ff @(posedge clk) begin
    start_q <= start_mem[idx];
    cnt_q   <= cnt_mem[idx];
    age_q   <= age_mem[idx];
    v_q     <= valid[idx];
    e_idx   <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_scan <= 1'b0;
      e_age  <= 1'b0;
    end else begin
      e_scan <= cmd.issue_scan;
      e_age  <= cmd.issue_age;
    end
  end

  // Run match: the sector lies in [start, start + count).
  assign scan_diff = {1'b0, lba} - {1'b0, start_q};
  assign cnt_wide  = {{(LBA_W - CW){1'b0}}, cnt_q};
  assign hit_here  = v_q && !scan_diff[LBA_W] && (scan_diff[LBA_W-1:0] < cnt_wide);
  assign age_eff   = v_q ? age_q : AGE_MAX;

  // Hit, first empty line and oldest line, one line per cycle.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found       <= 1'b0;
      empty_found <= 1'b0;
      oldest_age  <= '0;
      best_idx    <= '0;
    end else if (e_scan) begin
      if (hit_here && !found) begin
        found    <= 1'b1;
        hit_idx  <= e_idx;
        hit_offs <= scan_diff[OFFS_FW-1:0];
      end
      if (!v_q && !empty_found) begin
        empty_found <= 1'b1;
        empty_idx   <= e_idx;
      end
      if (v_q && (age_eff >= oldest_age)) begin
        oldest_age <= age_eff;
        best_idx   <= e_idx;
      end
    end
  end

  // Aging pass: the youngest line goes to 0, other valid lines count up to saturation.
  assign young   = (kind == KIND_FILL_DONE) ? pend_line : hit_idx;
  assign age_new = (e_idx == young) ? 8'd0 : age_q + 8'd1;
  assign age_we  = e_age && ((e_idx == young) || (v_q && (age_q != AGE_MAX)));

  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[e_idx] <= age_new;
    end
  end

  // Fill commit into the line memories.
  always_ff @(posedge clk) begin
    if (cmd.fill_write) begin
      start_mem[pend_line] <= pend_start;
      cnt_mem[pend_line]   <= pend_count;
    end
  end

  // Valid bits: set by a fill, cleared together by invalidate.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.commit && (kind == KIND_INVALIDATE)) begin
      valid <= '0;
    end else if (cmd.fill_write) begin
      valid[pend_line] <= 1'b1;
    end
  end

  // Read-ahead count clamped to the disk end.
  assign tot_diff = {1'b0, disk_total} - {1'b0, lba};

  always_comb begin
    ra = RA_FULL;
    if ((disk_total != '0) && (tot_diff[LBA_W] || (tot_diff[LBA_W-1:0] < RA_WIDE))) begin
      if (tot_diff[LBA_W] || (tot_diff[LBA_W-1:0] == '0)) begin
        ra = RA_ONE;
      end else begin
        ra = tot_diff[CW-1:0];
      end
    end
  end

  assign victim = empty_found ? empty_idx : best_idx;

  // Pending fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.commit) begin
      case (kind)
        KIND_LOOKUP: begin
          if (!found) begin
            pend_valid <= 1'b1;
          end
        end
        KIND_FILL_DONE:  pend_valid <= 1'b0;
        KIND_INVALIDATE: pend_valid <= 1'b0;
        default:         pend_valid <= pend_valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && (kind == KIND_LOOKUP) && !found) begin
      pend_line  <= victim;
      pend_start <= lba;
      pend_count <= ra;
    end
  end

  // Result register, masked to the field widths.
  assign hit_line_ext = {{LINE_FW{1'b0}}, hit_idx};
  assign victim_ext   = {{LINE_FW{1'b0}}, victim};
  assign ra_ext       = {{CNT_FW{1'b0}}, ra};
  assign out_free     = !out_vld || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (cmd.commit) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit        <= 1'b0;
      out_hit_line   <= '0;
      out_offs       <= '0;
      out_fill_req   <= 1'b0;
      out_fill_line  <= '0;
      out_fill_lba   <= '0;
      out_fill_count <= '0;
      if (kind == KIND_LOOKUP) begin
        if (found) begin
          out_hit      <= 1'b1;
          out_hit_line <= hit_line_ext[LINE_FW-1:0];
          out_offs     <= hit_offs;
        end else begin
          out_fill_req   <= 1'b1;
          out_fill_line  <= victim_ext[LINE_FW-1:0];
          out_fill_lba   <= lba;
          out_fill_count <= ra_ext[CNT_FW-1:0];
        end
      end
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {7'd0, out_fill_count, out_fill_lba, out_fill_line, out_fill_req,
                     out_offs, out_hit_line, out_hit};

  // Status to the controller.
  assign status.kind       = kind;
  assign status.fill_ok    = fill_ok;
  assign status.pend_valid = pend_valid;
  assign status.found      = found;
  assign status.idx_last   = (idx == IDX_LAST);
  assign status.out_free   = out_free;

`ifndef SYNTHESIS
  // A miss result leaves a fill pending.
  a_miss_pends: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (kind == KIND_LOOKUP) && !found) |=> pend_valid)
    else $error("miss did not leave a pending fill");

  // Invalidate cancels the pending fill and empties every line.
  a_inval_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (kind == KIND_INVALIDATE)) |=> (!pend_valid && (valid == '0)))
    else $error("invalidate left a pending fill or a valid line");

  // A line is only written while a fill is pending.
  a_fill_needs_pend: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_write |-> pend_valid)
    else $error("fill written with no pending fill");

  // A result is either a hit or a fill request, never both.
  a_hit_xor_fill: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> !(out_hit && out_fill_req))
    else $error("result flags both hit and fill request");

  // A new result is only loaded when the previous one is gone or taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_vld || m_tready))
    else $error("result register overwritten");
`endif

endmodule

[hdl/sector_cache_tag_lru_readahead.sv]
// Top level of the sector cache tag and replacement engine.
//
// Tag and LRU engine of a fully associative sector cache with read-ahead. One request is
// worked on at a time; its result goes to an output register so that the next request is
// taken while the result waits. The walk over the line table reads one line per cycle
// from the line memories. A lookup miss makes one scan pass, a lookup hit one scan pass
// and one aging pass, a successful fill done one aging pass, and any other request none.
// After reset the block is ready at once: lines are emptied by per-line valid bits.
// s_tuser holds kind; s_tdata holds lba [31:0] and fill_ok [32]. m_tdata holds hit [0],
// hit_line [4:1], sector_offset [7:5], fill_request [8], fill_line [12:9],
// fill_lba [44:13] and fill_count [48:45]. Writing cfg_wdata with cfg_wen sets the disk
// size in sectors (0 disables clamping); write it only while the block is idle.
module sector_cache_tag_lru_readahead
  import sclru_pkg::*;
#(
  parameter int LINE_COUNT = 16,
  parameter int READ_AHEAD = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [LBA_W-1:0]       cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // lba, fill_ok, zero pad
  input  logic [1:0]             s_tuser,   // kind
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // hit, hit_line, sector_offset, fill_request,
                                            // fill_line, fill_lba, fill_count, zero pad
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sclru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sclru_dp #(
    .LINE_COUNT (LINE_COUNT),
    .READ_AHEAD (READ_AHEAD)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

[sim/sector_cache_tag_lru_readahead_tb.sv]
// Self-checking testbench for the sector cache tag, LRU and read-ahead engine.
`timescale 1ns / 100ps

module sector_cache_tag_lru_readahead_tb;
  import sclru_pkg::*;

  localparam int LINES         = 16;
  localparam int SECTORS_AHEAD = 8;

  // The fourth request kind has no function and must leave all state alone.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]       kind;
    logic [LBA_W-1:0] lba;
    logic             fill_ok;
  } cache_req_t;

  typedef struct packed {
    logic               hit;
    logic [LINE_FW-1:0] hit_line;
    logic [OFFS_FW-1:0] sector_offset;
    logic               fill_request;
    logic [LINE_FW-1:0] fill_line;
    logic [LBA_W-1:0]   fill_lba;
    logic [CNT_FW-1:0]  fill_count;
  } cache_rsp_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wen = 1'b0;
  logic [LBA_W-1:0]       cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // lba, fill_ok, zero pad
  logic [1:0]             s_tuser = '0;   // kind
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // hit, hit_line, sector_offset, fill_request,
                                          // fill_line, fill_lba, fill_count, zero pad

  // Mirror of the line table, the pending fill and the disk size.
  logic [LBA_W-1:0]  line_start [LINES];
  logic [CNT_FW-1:0] line_cnt [LINES];
  logic [7:0]        line_age [LINES];
  logic              pend_valid;
  logic [LINE_FW-1:0] pend_line;
  logic [LBA_W-1:0]  pend_start;
  logic [CNT_FW-1:0] pend_cnt;
  logic [LBA_W-1:0]  disk_total;

  cache_req_t tag_req_q [$];
  cache_rsp_t tag_rsp_q [$];
  cache_req_t cur_req;
  int         reqs_unsent = 0;
  int         err_cnt = 0;
  int         src_gap = 0;
  int         sink_gap = 0;
  bit         req_fire = 1'b0;
  bit         idle_on = 1'b1;

  sector_cache_tag_lru_readahead #(
    .LINE_COUNT(LINES),
    .READ_AHEAD(SECTORS_AHEAD)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Make one line the youngest and age every other valid line, saturating.
  function automatic void promote_line(int idx);
    int i;
    for (i = 0; i < LINES; i++) begin
      if (i == idx) begin
        line_age[i] = 8'd0;
      end else if (line_cnt[i] != 0 && line_age[i] != AGE_MAX) begin
        line_age[i] = line_age[i] + 8'd1;
      end
    end
  endfunction

  // Apply one request to the mirrored state and return the result it must produce.
  function automatic cache_rsp_t cache_step(cache_req_t r);
    cache_rsp_t o;
    int         i;
    int         victim;
    logic [7:0] oldest;
    logic [LBA_W:0] reach;
    logic [CNT_FW-1:0] cnt;
    o = '0;
    case (r.kind)
      KIND_LOOKUP: begin
        // Tag match over 33 bits so a run at the top of the address space cannot wrap.
        for (i = 0; i < LINES && !o.hit; i++) begin
          reach = {1'b0, line_start[i]} + line_cnt[i];
          if (line_cnt[i] != 0 && r.lba >= line_start[i] && {1'b0, r.lba} < reach) begin
            o.hit = 1'b1;
            o.hit_line = LINE_FW'(i);
            o.sector_offset = OFFS_FW'(r.lba - line_start[i]);
          end
        end
        if (o.hit) begin
          promote_line(int'(o.hit_line));
        end else begin
          // Lowest empty line first, else the oldest with ties to the highest index.
          victim = LINES;
          for (i = LINES - 1; i >= 0; i--) begin
            if (line_cnt[i] == 0) victim = i;
          end
          if (victim == LINES) begin
            oldest = 8'd0;
            victim = 0;
            for (i = 0; i < LINES; i++) begin
              if (line_age[i] >= oldest) begin
                oldest = line_age[i];
                victim = i;
              end
            end
          end
          // Clamp the read-ahead at the disk end; at or past the end one sector is read.
          cnt = CNT_FW'(SECTORS_AHEAD);
          if (disk_total != 0 &&
              ({1'b0, r.lba} + 33'(SECTORS_AHEAD)) > {1'b0, disk_total}) begin
            if (r.lba >= disk_total) cnt = CNT_FW'(1);
            else cnt = CNT_FW'(disk_total - r.lba);
          end
          pend_valid = 1'b1;
          pend_line = LINE_FW'(victim);
          pend_start = r.lba;
          pend_cnt = cnt;
          o.fill_request = 1'b1;
          o.fill_line = LINE_FW'(victim);
          o.fill_lba = r.lba;
          o.fill_count = cnt;
        end
      end
      KIND_FILL_DONE: begin
        if (pend_valid && r.fill_ok) begin
          line_start[pend_line] = pend_start;
          line_cnt[pend_line] = pend_cnt;
          promote_line(int'(pend_line));
        end
        pend_valid = 1'b0;
      end
      KIND_INVALIDATE: begin
        for (i = 0; i < LINES; i++) begin
          line_cnt[i] = '0;
          line_age[i] = AGE_MAX;
        end
        pend_valid = 1'b0;
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // Request driver: present queued requests, with random gaps after acceptance.
  always @(negedge clk) begin
    logic nxt_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      nxt_valid = s_tvalid;
      if (req_fire) begin
        req_fire = 1'b0;
        nxt_valid = 1'b0;
        if (idle_on && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 10);
      end
      if (!nxt_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (tag_req_q.size() > 0) begin
          cur_req = tag_req_q.pop_front();
          s_tuser <= cur_req.kind;
          s_tdata <= {7'd0, cur_req.fill_ok, cur_req.lba};
          nxt_valid = 1'b1;
        end
      end
      s_tvalid <= nxt_valid;
    end
  end

  // Result sink: random stall bursts.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(0, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Check results against the oldest outstanding one, then record accepted requests.
  always @(posedge clk) begin
    cache_rsp_t got;
    cache_rsp_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.hit           = m_tdata[0];
        got.hit_line      = m_tdata[4:1];
        got.sector_offset = m_tdata[7:5];
        got.fill_request  = m_tdata[8];
        got.fill_line     = m_tdata[12:9];
        got.fill_lba      = m_tdata[44:13];
        got.fill_count    = m_tdata[48:45];
        if (tag_rsp_q.size() == 0) begin
          $error("result 0x%0h arrived with none outstanding", m_tdata);
          err_cnt++;
        end else begin
          want = tag_rsp_q.pop_front();
          check_field("hit", 32'(want.hit), 32'(got.hit));
          check_field("hit_line", 32'(want.hit_line), 32'(got.hit_line));
          check_field("sector_offset", 32'(want.sector_offset), 32'(got.sector_offset));
          check_field("fill_request", 32'(want.fill_request), 32'(got.fill_request));
          check_field("fill_line", 32'(want.fill_line), 32'(got.fill_line));
          check_field("fill_lba", want.fill_lba, got.fill_lba);
          check_field("fill_count", 32'(want.fill_count), 32'(got.fill_count));
        end
      end
      if (s_tvalid && s_tready) begin
        tag_rsp_q.push_back(cache_step(cur_req));
        reqs_unsent--;
        req_fire = 1'b1;
      end
    end
  end

  function automatic void push_req(logic [1:0] kind, logic [31:0] lba, logic ok);
    cache_req_t r;
    r.kind = kind;
    r.lba = lba;
    r.fill_ok = ok;
    tag_req_q.push_back(r);
    reqs_unsent++;
  endfunction

  // Wait until every queued request has been accepted and every result has come.
  task automatic drain();
    while (reqs_unsent != 0 || tag_rsp_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_disk_size(logic [31:0] v);
    drain();
    cfg_wdata <= v;
    cfg_wen <= 1'b1;
    @(negedge clk);
    cfg_wen <= 1'b0;
    disk_total = v;
  endtask

  // Mostly miss-then-fill sequences around a few hot regions, plus stray requests.
  task automatic random_phase(int n, logic [31:0] total);
    logic [31:0] bases [4];
    logic [31:0] a;
    int          pick;
    write_disk_size(total);
    bases[0] = 32'd0;
    bases[1] = 32'd40;
    bases[2] = (total > 12) ? total - 32'd12 : 32'd0;
    bases[3] = 32'hFFFF_FFE6;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      a = bases[$urandom_range(0, 3)] + $urandom_range(0, 25);
      if (pick < 76) begin
        push_req(KIND_LOOKUP, a, 1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 9);
        if (pick < 7) push_req(KIND_FILL_DONE, $urandom, 1'b1);
        else if (pick < 8) push_req(KIND_FILL_DONE, $urandom, 1'b0);
      end else if (pick < 78) begin
        push_req(KIND_INVALIDATE, $urandom, 1'($urandom_range(0, 1)));
      end else if (pick < 80) begin
        push_req(KIND_UNUSED, $urandom, 1'($urandom_range(0, 1)));
      end else if (pick < 90) begin
        push_req(KIND_LOOKUP, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        push_req(KIND_FILL_DONE, $urandom, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int k;
    for (k = 0; k < LINES; k++) begin
      line_start[k] = '0;
      line_cnt[k] = '0;
      line_age[k] = AGE_MAX;
    end
    pend_valid = 1'b0;
    pend_line = '0;
    pend_start = '0;
    pend_cnt = '0;
    disk_total = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Unclamped: hit at run end, failed fill, replaced fill, top-of-space run,
    // stray fill done, unused kind, and invalidate cancelling a pending fill.
    push_req(KIND_LOOKUP, 32'd0, 1'b0);
    push_req(KIND_FILL_DONE, 32'd0, 1'b1);
    push_req(KIND_LOOKUP, 32'd7, 1'b1);
    push_req(KIND_LOOKUP, 32'd8, 1'b0);
    push_req(KIND_FILL_DONE, 32'hFFFF_FFFF, 1'b0);
    push_req(KIND_LOOKUP, 32'd8, 1'b0);
    push_req(KIND_LOOKUP, 32'hFFFF_FFFC, 1'b0);
    push_req(KIND_FILL_DONE, 32'd0, 1'b1);
    push_req(KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0);
    push_req(KIND_FILL_DONE, 32'd0, 1'b1);
    push_req(KIND_UNUSED, 32'hFFFF_FFFF, 1'b1);
    push_req(KIND_LOOKUP, 32'd100, 1'b0);
    push_req(KIND_INVALIDATE, 32'hFFFF_FFFF, 1'b1);
    push_req(KIND_FILL_DONE, 32'd0, 1'b1);
    push_req(KIND_LOOKUP, 32'd0, 1'b0);

    // Small disk: partial read-ahead, lookup exactly at the end and far past it.
    write_disk_size(32'd20);
    push_req(KIND_LOOKUP, 32'd15, 1'b0);
    push_req(KIND_FILL_DONE, 32'd0, 1'b1);
    push_req(KIND_LOOKUP, 32'd20, 1'b0);
    push_req(KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0);
    push_req(KIND_LOOKUP, 32'd12, 1'b0);

    // Largest disk: clamping right at the top of the address space.
    write_disk_size(32'hFFFF_FFFF);
    push_req(KIND_LOOKUP, 32'hFFFF_FFFE, 1'b0);
    push_req(KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0);
    push_req(KIND_LOOKUP, 32'hFFFF_FFF7, 1'b0);

    // Fill every line, then keep one line hot until the others saturate at the
    // maximum age, so the victim tie goes to the highest index.
    write_disk_size(32'd0);
    push_req(KIND_INVALIDATE, 32'd0, 1'b0);
    for (k = 0; k < LINES; k++) begin
      push_req(KIND_LOOKUP, 32'd1000 + 8 * k, 1'b0);
      push_req(KIND_FILL_DONE, 32'd0, 1'b1);
    end
    repeat (260) push_req(KIND_LOOKUP, 32'd1040 + $urandom_range(0, 7), 1'b0);
    push_req(KIND_LOOKUP, 32'd5000, 1'b0);
    push_req(KIND_FILL_DONE, 32'd0, 1'b1);
    push_req(KIND_LOOKUP, 32'd5001, 1'b0);
    push_req(KIND_LOOKUP, 32'd6000, 1'b0);
    push_req(KIND_FILL_DONE, 32'd0, 1'b1);

    random_phase(25, 32'd1);
    random_phase(25, $urandom);
    random_phase(25, 32'hFFFF_FFFF);
    random_phase(25, 32'd90);
    drain();
    idle_on = 1'b0;
    random_phase(25, 32'd0);

    drain();
    repeat (2 * LINES + 8) @(posedge clk);
    if (err_cnt == 0 && tag_rsp_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[sector_cache_tag_lru_readahead.f]
hdl/sclru_pkg.sv
hdl/sclru_ctrl.sv
hdl/sclru_dp.sv
hdl/sector_cache_tag_lru_readahead.sv
sim/sector_cache_tag_lru_readahead_tb.sv
